@@ rtl/core/assert_macros.svh @@
// Assertion macros used by the priority queue RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed in the priority queue");

// Check that the consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed in the priority queue");

`endif

@@ rtl/core/tlpq_pkg.sv @@
// Types, codes and constants of the three-level priority queue.
package tlpq_pkg;

    // Default number of cells in the chain.
    localparam int unsigned DEPTH_DEFAULT = 16;

    // Request kinds.
    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_REMOVE = 1'b1;

    // Result status codes.
    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_EMPTY = 2'd1;
    localparam logic [1:0] STATUS_FULL  = 2'd2;

    // Priority levels; a larger code is a lower level.
    localparam logic [1:0] PRIO_HIGH = 2'd0;
    localparam logic [1:0] PRIO_LOW  = 2'd2;

    // Request payload.
    typedef struct packed {
        logic        req_type;
        logic [15:0] task_id;
        logic [1:0]  prio_level;
        logic [4:0]  due_day;
        logic [3:0]  due_month;
        logic [11:0] due_year;
    } req_t;

    // Response payload.
    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] out_id;
        logic [1:0]  out_prio;
        logic [4:0]  out_day;
        logic [3:0]  out_month;
        logic [11:0] out_year;
        logic [4:0]  fill_count;
    } rsp_t;

    // One stored task record.
    typedef struct packed {
        logic [15:0] task_id;
        logic [1:0]  prio;
        logic [4:0]  day;
        logic [3:0]  month;
        logic [11:0] year;
    } entry_t;

    // What one cell shows to its neighbors.
    typedef struct packed {
        logic   valid;
        entry_t entry;
    } cell_state_t;

    // Command broadcast to every cell in a cycle.
    typedef struct packed {
        logic   ins;
        logic   rem;
        entry_t entry;
    } cell_cmd_t;

    // Neighbor seen by the front cell: always occupied, never lower than a new entry.
    localparam cell_state_t CHAIN_HEAD = '{valid: 1'b1, entry: '0};

    // Neighbor seen by the back cell: always empty.
    localparam cell_state_t CHAIN_TAIL = '{valid: 1'b0, entry: '0};

endpackage

@@ rtl/core/three_level_priority_queue_unit.sv @@
// The response is registered at the same edge that accepts the request.
// Throughput: one request per cycle while responses are taken; every cell of the chain
// decides its next contents combinationally from itself and its two neighbors.
// A response waiting in the output register still lets a new request in when taken.
// Reset clears the cell occupancy flags, the entry count and the response valid;
// the stored records themselves are not cleared.
module three_level_priority_queue_unit #(
    parameter int unsigned DEPTH = tlpq_pkg::DEPTH_DEFAULT
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_ready,
    input  tlpq_pkg::req_t req_data,
    output logic           rsp_valid,
    input  logic           rsp_ready,
    output tlpq_pkg::rsp_t rsp_data
);
    import tlpq_pkg::*;
    `include "assert_macros.svh"

    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    logic              accept;
    logic              empty;
    logic              full;
    cell_cmd_t         cmd;
    cell_state_t       cells [DEPTH];
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              rsp_valid_reg;
    logic              rsp_valid_next;
    rsp_t              rsp_data_reg;
    rsp_t              rsp_data_next;
    logic [15:0]       front_id;

    // Handshake: the output register frees up when its response is taken.
    assign req_ready = !rsp_valid_reg || rsp_ready;
    assign accept    = req_valid && req_ready;
    assign empty     = !cells[0].valid;
    assign full      = cells[DEPTH-1].valid;
    assign front_id  = cells[0].entry.task_id;

    // Command to the chain, with level three saturated to low.
    always_comb
    begin
        cmd.ins            = accept && (req_data.req_type == REQ_INSERT) && !full;
        cmd.rem            = accept && (req_data.req_type == REQ_REMOVE) && !empty;
        cmd.entry.task_id  = req_data.task_id;
        cmd.entry.prio     = (req_data.prio_level > PRIO_LOW) ? PRIO_LOW
                                                              : req_data.prio_level;
        cmd.entry.day      = req_data.due_day;
        cmd.entry.month    = req_data.due_month;
        cmd.entry.year     = req_data.due_year;
    end

    // Chain of cells, front at index zero.
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        cell_state_t left_s;
        cell_state_t right_s;
        if (i == 0)
        begin : g_head
            assign left_s = CHAIN_HEAD;
        end
        else
        begin : g_mid_l
            assign left_s = cells[i-1];
        end
        if (i == DEPTH - 1)
        begin : g_tail
            assign right_s = CHAIN_TAIL;
        end
        else
        begin : g_mid_r
            assign right_s = cells[i+1];
        end
        tlpq_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .cmd   (cmd),
            .left  (left_s),
            .right (right_s),
            .state (cells[i])
        );
    end

    // Entry count.
    always_comb
    begin
        count_next = count_reg;
        if (cmd.ins)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (cmd.rem)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    // Response built from the request and the front cell.
    always_comb
    begin
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        rsp_data_next  = rsp_data_reg;
        if (accept)
        begin
            rsp_valid_next           = 1'b1;
            rsp_data_next            = '0;
            rsp_data_next.fill_count = 5'(count_next);
            if (req_data.req_type == REQ_INSERT)
            begin
                rsp_data_next.status = full ? STATUS_FULL : STATUS_OK;
            end
            else if (empty)
            begin
                rsp_data_next.status = STATUS_EMPTY;
            end
            else
            begin
                rsp_data_next.status    = STATUS_OK;
                rsp_data_next.out_id    = cells[0].entry.task_id;
                rsp_data_next.out_prio  = cells[0].entry.prio;
                rsp_data_next.out_day   = cells[0].entry.day;
                rsp_data_next.out_month = cells[0].entry.month;
                rsp_data_next.out_year  = cells[0].entry.year;
            end
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Response payload register.
    always_ff @(posedge clk)
    begin
        rsp_data_reg <= rsp_data_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

    // The count agrees with the occupancy of the chain ends.
    `ASSERT_SAME(a_empty_match, clk, rst_n, 1'b1, ((count_reg == '0) == empty))
    `ASSERT_SAME(a_full_match, clk, rst_n, 1'b1, ((count_reg == CNT_W'(DEPTH)) == full))
    // Every accepted request yields a response in the next cycle.
    `ASSERT_NEXT(a_rsp_follows, clk, rst_n, accept, rsp_valid_reg)
    // A successful remove returns the record that was at the front.
    `ASSERT_NEXT(a_remove_ok, clk, rst_n, cmd.rem, rsp_data_reg.status == STATUS_OK)
    `ASSERT_NEXT(a_remove_front, clk, rst_n, cmd.rem, rsp_data_reg.out_id == $past(front_id))

endmodule

@@ rtl/core/tlpq_cell.sv @@
// One cell of the shift-register priority queue.
module tlpq_cell (
    input  logic                  clk,
    input  logic                  rst_n,
    input  tlpq_pkg::cell_cmd_t   cmd,
    input  tlpq_pkg::cell_state_t left,
    input  tlpq_pkg::cell_state_t right,
    output tlpq_pkg::cell_state_t state
);
    import tlpq_pkg::*;

    logic   valid_reg;
    logic   valid_next;
    entry_t entry_reg;
    entry_t entry_next;
    logic   lower_self;
    logic   lower_left;

    // An entry of strictly lower level sits behind the new one.
    assign lower_self = valid_reg && (entry_reg.prio > cmd.entry.prio);
    assign lower_left = left.valid && (left.entry.prio > cmd.entry.prio);

    // Local decision: shift back, take the new entry, shift forward or hold.
    always_comb
    begin
        valid_next = valid_reg;
        entry_next = entry_reg;
        if (cmd.ins)
        begin
            valid_next = valid_reg || left.valid;
            if (lower_left)
            begin
                entry_next = left.entry;
            end
            else if (lower_self || (!valid_reg && left.valid))
            begin
                entry_next = cmd.entry;
            end
        end
        else if (cmd.rem)
        begin
            valid_next = right.valid;
            entry_next = right.entry;
        end
    end

    // Occupancy flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Record storage.
    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign state.valid = valid_reg;
    assign state.entry = entry_reg;

endmodule
